// ===== src/mdf_pkg.sv =====
// Shared types and constants for the MoldUDP64 deframer.
// No dependencies; used by every module in src.
package mdf_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int SEQ_FIRST    = 10;
  localparam int SEQ_LAST     = 17;
  localparam int POS_W        = 5;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 64;

  localparam logic [15:0] COUNT_HEARTBEAT   = 16'h0000;
  localparam logic [15:0] COUNT_END_SESSION = 16'hFFFF;

  localparam logic REG_EXPECTED_START_SEQ = 1'b0;

  localparam logic [2:0] KIND_MSG_BYTE  = 3'd0;
  localparam logic [2:0] KIND_EMPTY_MSG = 3'd1;
  localparam logic [2:0] KIND_GAP       = 3'd2;
  localparam logic [2:0] KIND_HEARTBEAT = 3'd3;
  localparam logic [2:0] KIND_END_SESS  = 3'd4;
  localparam logic [2:0] KIND_MISSING   = 3'd5;
  localparam logic [2:0] KIND_TRUNCATED = 3'd6;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_DATA,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        msg_first;
    logic        msg_last;
    logic [15:0] msg_length;
    logic [63:0] packet_seq;
    logic [63:0] gap_start;
    logic [15:0] gap_count;
    logic        cut_short;
  } result_t;

endpackage

// ===== src/mdf_ifs.sv =====
// Valid/ready channel interfaces for the deframer's byte input and result output.
// Depends on nothing beyond the language.
interface mdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       datagram_end;

  modport source (output valid, output payload_byte, output datagram_end, input ready);
  modport sink (input valid, input payload_byte, input datagram_end, output ready);
endinterface

interface mdf_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic        msg_first;
  logic        msg_last;
  logic [15:0] msg_length;
  logic [63:0] packet_seq;
  logic [63:0] gap_start;
  logic [15:0] gap_count;
  logic        cut_short;

  modport source (
    output valid, output kind, output data_byte, output msg_first, output msg_last,
    output msg_length, output packet_seq, output gap_start, output gap_count,
    output cut_short, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input msg_first, input msg_last,
    input msg_length, input packet_seq, input gap_start, input gap_count,
    input cut_short, output ready
  );
endinterface

// ===== src/mdf_apb_regs.sv =====
// APB register file holding expected_start_seq.
// Depends on mdf_pkg.
module mdf_apb_regs
  import mdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [63:0]       expected_start_seq
);

  logic hit;

  assign hit    = paddr[ADDR_W-1] == REG_EXPECTED_START_SEQ;
  assign pready = 1'b1;
  assign prdata = hit ? expected_start_seq : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_start_seq <= '0;
    end else if (psel && penable && pwrite && hit) begin
      expected_start_seq <= pwdata;
    end
  end

endmodule

// ===== src/mdf_parse.sv =====
// Deframing state machine: header, length prefix, message data and skip phases.
// Produces at most one result per consumed byte. Depends on mdf_pkg.
module mdf_parse
  import mdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  payload_byte,
  input  logic        datagram_end,
  input  logic [63:0] expected_start_seq,
  output logic        res_valid,
  output result_t     res
);

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   header_pos, header_pos_next;
  logic [63:0]        seq_accum, seq_accum_next;
  logic [15:0]        count_accum, count_accum_next;
  logic [15:0]        messages_left, messages_left_next;
  logic [15:0]        bytes_left, bytes_left_next;
  logic               length_high_seen, length_high_seen_next;
  logic               first_datagram, first_datagram_next;

  logic        in_seq, in_cnt, at_seq_last, hdr_done, gap_hit;
  logic [63:0] seq_cur;
  logic [15:0] cnt_cur, len_full, msgs_dec;
  logic        cnt_special, data_first, data_last;

  assign in_seq      = header_pos >= POS_W'(SEQ_FIRST) && header_pos <= POS_W'(SEQ_LAST);
  assign in_cnt      = header_pos >= POS_W'(HEADER_BYTES - 2);
  assign at_seq_last = header_pos == POS_W'(SEQ_LAST);
  assign hdr_done    = header_pos >= POS_W'(HEADER_BYTES - 1);
  assign seq_cur     = (phase == PH_HEADER && in_seq) ? {seq_accum[55:0], payload_byte}
                                                      : seq_accum;
  assign cnt_cur     = (phase == PH_HEADER && in_cnt && !in_seq)
                       ? {count_accum[7:0], payload_byte} : count_accum;
  assign cnt_special = cnt_cur == COUNT_HEARTBEAT || cnt_cur == COUNT_END_SESSION;
  assign gap_hit     = at_seq_last && first_datagram && seq_cur != expected_start_seq;
  assign len_full    = {bytes_left[15:8], payload_byte};
  assign msgs_dec    = messages_left - 16'd1;
  assign data_first  = bytes_left == count_accum;
  assign data_last   = bytes_left <= 16'd1;

  always_comb begin
    phase_next            = phase;
    header_pos_next       = header_pos;
    seq_accum_next        = seq_accum;
    count_accum_next      = count_accum;
    messages_left_next    = messages_left;
    bytes_left_next       = bytes_left;
    length_high_seen_next = length_high_seen;
    first_datagram_next   = first_datagram;
    if (take) begin
      case (phase)
        PH_HEADER: begin
          seq_accum_next   = seq_cur;
          count_accum_next = cnt_cur;
          if (at_seq_last && first_datagram) begin
            first_datagram_next = 1'b0;
          end
          if (hdr_done) begin
            if (cnt_special) begin
              phase_next = PH_SKIP;
            end else if (!datagram_end) begin
              messages_left_next    = cnt_cur;
              length_high_seen_next = 1'b0;
              phase_next            = PH_LENGTH;
            end
          end
          header_pos_next = header_pos + POS_W'(1);
        end
        PH_LENGTH: begin
          if (!length_high_seen) begin
            bytes_left_next       = {payload_byte, 8'h00};
            length_high_seen_next = 1'b1;
          end else begin
            length_high_seen_next = 1'b0;
            count_accum_next      = len_full;
            bytes_left_next       = len_full;
            if (len_full == 16'd0) begin
              messages_left_next = msgs_dec;
              phase_next         = (msgs_dec != 16'd0) ? PH_LENGTH : PH_SKIP;
            end else if (!datagram_end) begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          bytes_left_next = bytes_left - 16'd1;
          if (data_last) begin
            messages_left_next    = msgs_dec;
            phase_next            = (msgs_dec != 16'd0) ? PH_LENGTH : PH_SKIP;
            length_high_seen_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (datagram_end) begin
        phase_next            = PH_HEADER;
        header_pos_next       = '0;
        length_high_seen_next = 1'b0;
      end
    end
  end

  always_comb begin
    res            = '0;
    res_valid      = 1'b0;
    res.packet_seq = seq_cur;
    case (phase)
      PH_HEADER: begin
        if (gap_hit) begin
          res_valid     = 1'b1;
          res.kind      = KIND_GAP;
          res.cut_short = datagram_end;
          res.gap_start = expected_start_seq;
          res.gap_count = seq_cur[15:0] - expected_start_seq[15:0];
        end
        if (hdr_done) begin
          if (cnt_cur == COUNT_HEARTBEAT) begin
            res_valid = 1'b1;
            res.kind  = KIND_HEARTBEAT;
          end else if (cnt_cur == COUNT_END_SESSION) begin
            res_valid = 1'b1;
            res.kind  = KIND_END_SESS;
          end else if (datagram_end) begin
            res_valid     = 1'b1;
            res.kind      = KIND_MISSING;
            res.cut_short = 1'b1;
          end
        end else if (datagram_end && !gap_hit) begin
          res_valid      = 1'b1;
          res.kind       = KIND_TRUNCATED;
          res.cut_short  = 1'b1;
          res.packet_seq = (header_pos >= POS_W'(SEQ_LAST)) ? seq_cur : '0;
        end
      end
      PH_LENGTH: begin
        if (!length_high_seen) begin
          if (datagram_end) begin
            res_valid     = 1'b1;
            res.kind      = KIND_TRUNCATED;
            res.cut_short = 1'b1;
          end
        end else if (len_full == 16'd0) begin
          res_valid     = 1'b1;
          res.kind      = KIND_EMPTY_MSG;
          res.cut_short = datagram_end && msgs_dec != 16'd0;
        end else if (datagram_end) begin
          res_valid      = 1'b1;
          res.kind       = KIND_TRUNCATED;
          res.cut_short  = 1'b1;
          res.msg_length = len_full;
        end
      end
      PH_DATA: begin
        res_valid      = 1'b1;
        res.kind       = KIND_MSG_BYTE;
        res.data_byte  = payload_byte;
        res.msg_first  = data_first;
        res.msg_last   = data_last;
        res.msg_length = count_accum;
        res.cut_short  = datagram_end && !(data_last && msgs_dec == 16'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_pos       <= '0;
      seq_accum        <= '0;
      count_accum      <= '0;
      messages_left    <= '0;
      bytes_left       <= '0;
      length_high_seen <= 1'b0;
      first_datagram   <= 1'b1;
    end else begin
      phase            <= phase_next;
      header_pos       <= header_pos_next;
      seq_accum        <= seq_accum_next;
      count_accum      <= count_accum_next;
      messages_left    <= messages_left_next;
      bytes_left       <= bytes_left_next;
      length_high_seen <= length_high_seen_next;
      first_datagram   <= first_datagram_next;
    end
  end

endmodule

// ===== src/moldudp64_packet_deframer_top.sv =====
// MoldUDP64 deframer top level: input byte register, parser, result register.
// A byte waits in the input register while the result register is held by back-pressure;
// its result is valid the cycle after the parser takes it. One byte per cycle unless stalled.
// Reset (rst, synchronous): parser returns to the header phase, first-datagram check armed,
// expected_start_seq cleared to 0, both pipeline registers empty.
// Depends on mdf_pkg, mdf_ifs, mdf_apb_regs and mdf_parse.
module moldudp64_packet_deframer_top
  import mdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  mdf_byte_if.sink          stream,
  mdf_result_if.source      report,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_end;
  logic        out_valid;
  result_t     out_res;
  logic        out_free, take, stream_fire;
  logic        res_valid;
  result_t     res;
  logic [63:0] expected_start_seq;

  mdf_apb_regs u_regs (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .expected_start_seq (expected_start_seq)
  );

  mdf_parse u_parse (
    .clk                (clk),
    .rst                (rst),
    .take               (take),
    .payload_byte       (in_byte),
    .datagram_end       (in_end),
    .expected_start_seq (expected_start_seq),
    .res_valid          (res_valid),
    .res                (res)
  );

  assign out_free     = !out_valid || report.ready;
  assign take         = in_valid && out_free;
  assign stream.ready = !in_valid || out_free;
  assign stream_fire  = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream_fire) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream_fire) begin
      in_byte <= stream.payload_byte;
      in_end  <= stream.datagram_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && res_valid) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_res <= res;
    end
  end

  assign report.valid      = out_valid;
  assign report.kind       = out_res.kind;
  assign report.data_byte  = out_res.data_byte;
  assign report.msg_first  = out_res.msg_first;
  assign report.msg_last   = out_res.msg_last;
  assign report.msg_length = out_res.msg_length;
  assign report.packet_seq = out_res.packet_seq;
  assign report.gap_start  = out_res.gap_start;
  assign report.gap_count  = out_res.gap_count;
  assign report.cut_short  = out_res.cut_short;

endmodule
